@@ hdl/siu_pkg.sv @@
package siu_pkg;

    // item field widths
    localparam int ACT_W  = 2;
    localparam int ADDR_W = 12;
    localparam int RIDX_W = 4;
    localparam int WORD_W = 32;
    localparam int BYTE_W = 8;
    localparam int ADV_W  = 3;

    // stream payload widths
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 72;

    typedef enum logic [ACT_W-1:0] {
        ACT_WRITE_BYTE = 2'd0,
        ACT_WRITE_REG  = 2'd1,
        ACT_EXECUTE    = 2'd2,
        ACT_READ_BYTE  = 2'd3
    } action_t;

    // term codes of the type byte; any other code is an indirect term
    localparam logic [1:0] TERM_REG = 2'd1;
    localparam logic [1:0] TERM_DIR = 2'd2;

    // opcode byte, type byte and source register byte
    localparam logic [ADV_W-1:0] HEADER_LEN = 3'd3;

    function automatic logic [WORD_W-1:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

@@ hdl/siu_rem.sv @@
module siu_rem #(
    parameter int REACH_MODULUS = 512
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      start,
    input  logic [siu_pkg::WORD_W-1:0]                value,
    output logic                                      done,
    output logic signed [$clog2(REACH_MODULUS)+1:0]   remainder
);
    import siu_pkg::*;

    localparam int RW = $clog2(REACH_MODULUS) + 1;
    // scaled reciprocal of the modulus, the quotient estimate is low by at most one
    localparam logic [WORD_W-1:0] RECIP = WORD_W'((64'd1 << WORD_W) / REACH_MODULUS);
    localparam logic [RW-1:0]     MOD   = RW'(REACH_MODULUS);

    logic [WORD_W-1:0]   mag_reg;
    logic                neg_reg;
    logic [RW-1:0]       q_reg;
    logic [RW-1:0]       r_reg;
    logic                mul_reg;
    logic                fix_reg;
    logic                done_reg;

    logic [2*WORD_W-1:0] prod;
    logic [RW-1:0]       diff;
    logic [RW-1:0]       r_fix;
    logic signed [RW:0]  r_pos;

    assign prod  = {{WORD_W{1'b0}}, mag_reg} * {{WORD_W{1'b0}}, RECIP};
    // low bits suffice, the true difference lies below twice the modulus
    assign diff  = mag_reg[RW-1:0] - q_reg * MOD;
    assign r_fix = (diff >= MOD) ? diff - MOD : diff;

    // start, quotient estimate, correction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_reg  <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            mul_reg  <= 1'b1;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            mul_reg <= 1'b0;
            fix_reg <= mul_reg;
            if (fix_reg) begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mag_reg <= value[WORD_W-1] ? (~value + 1'b1) : value;
            neg_reg <= value[WORD_W-1];
        end
        if (mul_reg) begin
            q_reg <= prod[WORD_W +: RW];
        end
        if (fix_reg) begin
            r_reg <= r_fix;
        end
    end

    // remainder takes the sign of the dividend
    assign r_pos     = signed'({1'b0, r_reg});
    assign remainder = neg_reg ? -r_pos : r_pos;
    assign done      = done_reg;

endmodule

@@ hdl/siu_arena.sv @@
module siu_arena #(
    parameter int ARENA_BYTES = 4096
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               rd_en,
    input  logic                               wr_en,
    input  logic [$clog2(ARENA_BYTES)-1:0]     addr,
    input  logic [siu_pkg::BYTE_W-1:0]         wr_data,
    output logic [siu_pkg::BYTE_W-1:0]         rd_data,
    output logic                               clearing
);
    import siu_pkg::*;

    localparam int AW = $clog2(ARENA_BYTES);

    logic [BYTE_W-1:0] mem [ARENA_BYTES];
    logic [BYTE_W-1:0] rd_data_reg;
    logic [AW-1:0]     clr_addr_reg;
    logic              clr_busy_reg;

    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [BYTE_W-1:0] mem_wd;

    // the clearing sweep owns the write port after reset
    assign mem_we   = clr_busy_reg | wr_en;
    assign mem_addr = clr_busy_reg ? clr_addr_reg : addr;
    assign mem_wd   = clr_busy_reg ? '0 : wr_data;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wd;
        end
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(ARENA_BYTES - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clr_busy_reg;

endmodule

@@ hdl/siu_regfile.sv @@
module siu_regfile #(
    parameter int REGISTER_COUNT = 16
) (
    input  logic                                                        aclk,
    input  logic                                                        aresetn,
    input  logic                                                        wr_en,
    input  logic [((REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1)-1:0] wr_index,
    input  logic [siu_pkg::WORD_W-1:0]                                  wr_data,
    input  logic                                                        rd_en,
    input  logic [((REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1)-1:0] rd_index,
    output logic [siu_pkg::WORD_W-1:0]                                  rd_data
);
    import siu_pkg::*;

    logic [WORD_W-1:0]         mem [REGISTER_COUNT];
    logic [REGISTER_COUNT-1:0] valid_reg;
    logic [WORD_W-1:0]         rd_word_reg;
    logic                      rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_index] <= wr_data;
        end
        if (rd_en) begin
            rd_word_reg <= mem[rd_index];
        end
    end

    // never written entries read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_index] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_index];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

@@ hdl/store_indirect_instruction_unit.sv @@
// channel   direction  handshake           payload
// s_        in         s_tvalid/s_tready   s_tuser action, s_tdata address, register index, word
// m_        out        m_tvalid/m_tready   m_tdata one result per input transfer
//
// one item at a time
// execute time is set by the single arena port (one byte a cycle)
// and the remainder unit (reciprocal multiply and one correction)
// after reset the arena is swept to zero with s_tready low
// a finished result waits in the output register while the next input transfer is taken
module store_indirect_instruction_unit #(
    parameter int ARENA_BYTES    = 4096,
    parameter int REACH_MODULUS  = 512,
    parameter int REGISTER_COUNT = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [1:0] action
    input  logic [siu_pkg::ACT_W-1:0]        s_tuser,
    // [11:0] address, [15:12] register_index, [47:16] data_word
    input  logic [siu_pkg::S_TDATA_W-1:0]    s_tdata,

    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [7:0] read_byte, [8] stored, [20:9] store_address, [52:21] stored_value,
    // [55:53] advance, [67:56] next_pc, [71:68] zero
    output logic [siu_pkg::M_TDATA_W-1:0]    m_tdata
);
    import siu_pkg::*;

    localparam int AW    = $clog2(ARENA_BYTES);
    localparam int TW    = AW + 5;                 // signed address math, holds pc +/- reach
    localparam int IW    = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
    localparam int REM_W = $clog2(REACH_MODULUS) + 2;
    localparam int M_PAD = M_TDATA_W - (BYTE_W + 1 + ADDR_W + WORD_W + ADV_W + ADDR_W);

    localparam logic signed [TW-1:0] ARENA_1 = TW'(ARENA_BYTES);
    localparam logic signed [TW-1:0] ARENA_2 = TW'(2 * ARENA_BYTES);
    localparam logic signed [TW-1:0] ARENA_4 = TW'(4 * ARENA_BYTES);
    localparam logic signed [TW-1:0] ARENA_8 = TW'(8 * ARENA_BYTES);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRB,      // arena byte write
        ST_WRR,      // register write
        ST_FETCH,    // read a run of arena bytes into the shift register
        ST_SRC,      // check source register byte
        ST_VAL,      // source register word returns
        ST_TERM,     // start one term
        ST_TREG,     // register term byte arrived
        ST_TREGW,    // register term word returns
        ST_TWORD,    // 16-bit term value arrived
        ST_OFFREM,   // indirect offset remainder
        ST_IND,      // indirect word arrived
        ST_NEXT,     // second term or wrap up
        ST_SUMREM,   // sum remainder
        ST_STORE,    // four byte store, big-endian
        ST_DONE      // load output register
    } state_t;

    // reduce pc +/- reach into the arena; input lies in [-8*arena, 15*arena)
    function automatic logic [AW-1:0] arena_wrap(input logic signed [TW-1:0] t);
        logic signed [TW-1:0] u;
        u = t;
        if (u < 0) begin
            u = u + ARENA_8;
        end
        if (u >= ARENA_8) begin
            u = u - ARENA_8;
        end
        if (u >= ARENA_4) begin
            u = u - ARENA_4;
        end
        if (u >= ARENA_2) begin
            u = u - ARENA_2;
        end
        if (u >= ARENA_1) begin
            u = u - ARENA_1;
        end
        return u[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        logic [AW:0] n;
        n = {1'b0, p} + 1'b1;
        return (n == (AW + 1)'(ARENA_BYTES)) ? '0 : n[AW-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] fit_addr(input logic [AW-1:0] a);
        logic [AW+ADDR_W-1:0] e;
        e = {{ADDR_W{1'b0}}, a};
        return e[ADDR_W-1:0];
    endfunction

    function automatic logic reg_ok(input logic [7:0] b);
        return (b != 8'd0) && (b <= 8'(REGISTER_COUNT));
    endfunction

    // ---------------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------------
    state_t                 state_reg,    state_next;
    state_t                 ret_reg,      ret_next;
    action_t                action_reg,   action_next;
    logic [AW-1:0]          pc_reg,       pc_next;
    logic [RIDX_W-1:0]      idx_reg,      idx_next;
    logic [WORD_W-1:0]      data_reg,     data_next;
    logic [AW-1:0]          ptr_reg,      ptr_next;
    logic [2:0]             fcnt_reg,     fcnt_next;
    logic                   pend_reg,     pend_next;
    logic [WORD_W-1:0]      acc_reg,      acc_next;
    logic [7:0]             type_reg,     type_next;
    logic [WORD_W-1:0]      value_reg,    value_next;
    logic [WORD_W-1:0]      sum_reg,      sum_next;
    logic [ADV_W-1:0]       walk_reg,     walk_next;
    logic                   term_reg,     term_next;
    logic                   bad_reg,      bad_next;
    logic                   stored_reg,   stored_next;
    logic [AW-1:0]          saddr_reg,    saddr_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg,  m_tdata_next;

    // ---------------------------------------------------------------------
    // memory and remainder unit hookups
    // ---------------------------------------------------------------------
    logic                   ar_re, ar_we, ar_clearing;
    logic [AW-1:0]          ar_addr;
    logic [BYTE_W-1:0]      ar_wdata, ar_rdata;

    logic                   rf_re, rf_we;
    logic [IW-1:0]          rf_raddr, rf_waddr;
    logic [WORD_W-1:0]      rf_wdata, rf_rdata;

    logic                   rem_start, rem_done;
    logic [WORD_W-1:0]      rem_value;
    logic signed [REM_W-1:0] rem_out;

    // input transfer fields
    logic [ADDR_W-1:0]      in_address;
    logic [RIDX_W-1:0]      in_ridx;
    logic [WORD_W-1:0]      in_word;
    logic [AW-1:0]          in_pc;

    logic [1:0]             term_code;
    logic signed [TW-1:0]   pc_t, walk_t, rem_t;
    logic                   in_accept, out_free;
    logic                   is_exec;
    logic [AW-1:0]          next_pc_w;

    assign in_address = s_tdata[ADDR_W-1:0];
    assign in_ridx    = s_tdata[ADDR_W +: RIDX_W];
    assign in_word    = s_tdata[ADDR_W + RIDX_W +: WORD_W];
    assign in_pc      = arena_wrap(signed'(TW'(in_address)));

    assign s_tready  = (state_reg == ST_IDLE) && !ar_clearing;
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    // first term from type bits 5:4, second from bits 3:2
    assign term_code = term_reg ? type_reg[3:2] : type_reg[5:4];

    assign pc_t   = signed'(TW'(pc_reg));
    assign walk_t = signed'(TW'(walk_reg));
    assign rem_t  = TW'(rem_out);

    assign is_exec   = (action_reg == ACT_EXECUTE);
    assign next_pc_w = arena_wrap(pc_t + walk_t);

    siu_arena #(
        .ARENA_BYTES (ARENA_BYTES)
    ) u_arena (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (ar_re),
        .wr_en    (ar_we),
        .addr     (ar_addr),
        .wr_data  (ar_wdata),
        .rd_data  (ar_rdata),
        .clearing (ar_clearing)
    );

    siu_regfile #(
        .REGISTER_COUNT (REGISTER_COUNT)
    ) u_regfile (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (rf_we),
        .wr_index (rf_waddr),
        .wr_data  (rf_wdata),
        .rd_en    (rf_re),
        .rd_index (rf_raddr),
        .rd_data  (rf_rdata)
    );

    siu_rem #(
        .REACH_MODULUS (REACH_MODULUS)
    ) u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (rem_start),
        .value     (rem_value),
        .done      (rem_done),
        .remainder (rem_out)
    );

    // ---------------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------------
    always_comb begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        action_next   = action_reg;
        pc_next       = pc_reg;
        idx_next      = idx_reg;
        data_next     = data_reg;
        ptr_next      = ptr_reg;
        fcnt_next     = fcnt_reg;
        pend_next     = pend_reg;
        acc_next      = acc_reg;
        type_next     = type_reg;
        value_next    = value_reg;
        sum_next      = sum_reg;
        walk_next     = walk_reg;
        term_next     = term_reg;
        bad_next      = bad_reg;
        stored_next   = stored_reg;
        saddr_next    = saddr_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        ar_re     = 1'b0;
        ar_we     = 1'b0;
        ar_addr   = ptr_reg;
        ar_wdata  = acc_reg[WORD_W-1 -: BYTE_W];
        rf_re     = 1'b0;
        rf_raddr  = IW'(acc_reg[7:0] - 8'd1);
        rf_we     = 1'b0;
        rf_waddr  = IW'(idx_reg);
        rf_wdata  = data_reg;
        rem_start = 1'b0;
        rem_value = sum_reg;

        // the taken result leaves the output register
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    action_next = action_t'(s_tuser);
                    pc_next     = in_pc;
                    idx_next    = in_ridx;
                    data_next   = in_word;
                    walk_next   = '0;
                    sum_next    = '0;
                    term_next   = 1'b0;
                    bad_next    = 1'b0;
                    stored_next = 1'b0;
                    saddr_next  = '0;
                    pend_next   = 1'b0;
                    case (action_t'(s_tuser))
                        ACT_WRITE_BYTE: state_next = ST_WRB;
                        ACT_WRITE_REG:  state_next = ST_WRR;
                        ACT_READ_BYTE: begin
                            ptr_next   = in_pc;
                            fcnt_next  = 3'd1;
                            ret_next   = ST_DONE;
                            state_next = ST_FETCH;
                        end
                        ACT_EXECUTE: begin
                            // type byte then source register byte
                            ptr_next   = ptr_inc(in_pc);
                            fcnt_next  = 3'd2;
                            ret_next   = ST_SRC;
                            state_next = ST_FETCH;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end

            ST_WRB: begin
                ar_we      = 1'b1;
                ar_addr    = pc_reg;
                ar_wdata   = data_reg[BYTE_W-1:0];
                state_next = ST_DONE;
            end

            ST_WRR: begin
                // indexes past the register file are dropped
                rf_we      = ({4'b0, idx_reg} < 8'(REGISTER_COUNT));
                state_next = ST_DONE;
            end

            ST_FETCH: begin
                // one read issued per cycle, data lands in the cycle after
                if (pend_reg) begin
                    acc_next = {acc_reg[WORD_W-BYTE_W-1:0], ar_rdata};
                end
                if (fcnt_reg != 3'd0) begin
                    ar_re     = 1'b1;
                    ar_addr   = ptr_reg;
                    ptr_next  = ptr_inc(ptr_reg);
                    fcnt_next = fcnt_reg - 3'd1;
                    pend_next = 1'b1;
                end else begin
                    pend_next  = 1'b0;
                    state_next = ret_reg;
                end
            end

            ST_SRC: begin
                type_next = acc_reg[15:8];
                if (reg_ok(acc_reg[7:0])) begin
                    rf_re      = 1'b1;
                    walk_next  = HEADER_LEN;
                    state_next = ST_VAL;
                end else begin
                    state_next = ST_DONE;
                end
            end

            ST_VAL: begin
                value_next = rf_rdata;
                state_next = ST_TERM;
            end

            ST_TERM: begin
                ptr_next  = next_pc_w;
                pend_next = 1'b0;
                if (term_code == TERM_REG) begin
                    fcnt_next = 3'd1;
                    walk_next = walk_reg + 3'd1;
                    ret_next  = ST_TREG;
                end else begin
                    fcnt_next = 3'd2;
                    walk_next = walk_reg + 3'd2;
                    ret_next  = ST_TWORD;
                end
                state_next = ST_FETCH;
            end

            ST_TREG: begin
                if (reg_ok(acc_reg[7:0])) begin
                    rf_re      = 1'b1;
                    state_next = ST_TREGW;
                end else begin
                    // bad term register: walk still counts, no store
                    bad_next   = 1'b1;
                    state_next = ST_NEXT;
                end
            end

            ST_TREGW: begin
                sum_next   = sum_reg + rf_rdata;
                state_next = ST_NEXT;
            end

            ST_TWORD: begin
                if (term_code == TERM_DIR) begin
                    sum_next   = sum_reg + sext16(acc_reg[15:0]);
                    state_next = ST_NEXT;
                end else begin
                    rem_start  = 1'b1;
                    rem_value  = sext16(acc_reg[15:0]);
                    state_next = ST_OFFREM;
                end
            end

            ST_OFFREM: begin
                if (rem_done) begin
                    ptr_next   = arena_wrap(pc_t + rem_t);
                    fcnt_next  = 3'd4;
                    pend_next  = 1'b0;
                    ret_next   = ST_IND;
                    state_next = ST_FETCH;
                end
            end

            ST_IND: begin
                sum_next   = sum_reg + acc_reg;
                state_next = ST_NEXT;
            end

            ST_NEXT: begin
                if (!term_reg) begin
                    term_next  = 1'b1;
                    state_next = ST_TERM;
                end else if (bad_reg) begin
                    state_next = ST_DONE;
                end else begin
                    rem_start  = 1'b1;
                    rem_value  = sum_reg;
                    state_next = ST_SUMREM;
                end
            end

            ST_SUMREM: begin
                if (rem_done) begin
                    ptr_next    = arena_wrap(pc_t + rem_t);
                    saddr_next  = arena_wrap(pc_t + rem_t);
                    stored_next = 1'b1;
                    acc_next    = value_reg;
                    fcnt_next   = 3'd4;
                    state_next  = ST_STORE;
                end
            end

            ST_STORE: begin
                // most significant byte first
                ar_we     = 1'b1;
                ar_addr   = ptr_reg;
                ar_wdata  = acc_reg[WORD_W-1 -: BYTE_W];
                acc_next  = {acc_reg[WORD_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
                ptr_next  = ptr_inc(ptr_reg);
                fcnt_next = fcnt_reg - 3'd1;
                if (fcnt_reg == 3'd1) begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {
                        {M_PAD{1'b0}},
                        is_exec ? fit_addr(next_pc_w) : {ADDR_W{1'b0}},
                        walk_reg,
                        stored_reg ? value_reg : {WORD_W{1'b0}},
                        fit_addr(saddr_reg),
                        stored_reg,
                        (action_reg == ACT_READ_BYTE) ? acc_reg[BYTE_W-1:0] : {BYTE_W{1'b0}}
                    };
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            ret_reg      <= ret_next;
            action_reg   <= action_next;
            pc_reg       <= pc_next;
            idx_reg      <= idx_next;
            data_reg     <= data_next;
            ptr_reg      <= ptr_next;
            fcnt_reg     <= fcnt_next;
            pend_reg     <= pend_next;
            acc_reg      <= acc_next;
            type_reg     <= type_next;
            value_reg    <= value_next;
            sum_reg      <= sum_next;
            walk_reg     <= walk_next;
            term_reg     <= term_next;
            bad_reg      <= bad_next;
            stored_reg   <= stored_next;
            saddr_reg    <= saddr_next;
            m_tdata_reg  <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ test/tb_store_indirect_instruction_unit.sv @@
localparam int ARENA_SIZE = 4096;
localparam int REACH      = 512;
localparam int REG_COUNT  = 16;

// one result transfer, msb first, matches m_tdata[67:0]
typedef struct packed {
    logic [11:0] next_pc;
    logic [2:0]  advance;
    logic [31:0] stored_value;
    logic [11:0] store_address;
    logic        stored;
    logic [7:0]  read_byte;
} sti_result_t;

class sti_scoreboard;
    logic [7:0]  arena [ARENA_SIZE];
    logic [31:0] regs [REG_COUNT];
    sti_result_t expected_q [$];
    int          errors;

    function new();
        foreach (arena[i]) arena[i] = 8'h00;
        foreach (regs[i]) regs[i] = 32'h0;
        errors = 0;
    endfunction

    function int wrap(int a);
        int r;
        r = a % ARENA_SIZE;
        if (r < 0) r += ARENA_SIZE;
        return r;
    endfunction

    function logic [7:0] byte_at(int a);
        return arena[wrap(a)];
    endfunction

    function bit reg_ok(logic [7:0] b);
        return b >= 1 && b <= REG_COUNT;
    endfunction

    // one term at pc+walk; 0 when a register term names no register
    function bit add_term(int pc, logic [1:0] code, inout int walk, inout logic [31:0] sum);
        int          p;
        int          off;
        logic [7:0]  r;
        logic [15:0] raw;
        logic [31:0] w;
        p = pc + walk;
        if (code == siu_pkg::TERM_REG) begin
            r = byte_at(p);
            walk += 1;
            if (!reg_ok(r)) return 1'b0;
            sum += regs[r - 1];
            return 1'b1;
        end
        raw = {byte_at(p), byte_at(p + 1)};
        walk += 2;
        if (code == siu_pkg::TERM_DIR) begin
            sum += {{16{raw[15]}}, raw};
            return 1'b1;
        end
        off = $signed(raw) % REACH;
        w = {byte_at(pc + off), byte_at(pc + off + 1), byte_at(pc + off + 2),
             byte_at(pc + off + 3)};
        sum += w;
        return 1'b1;
    endfunction

    function void note_input(siu_pkg::action_t act, logic [11:0] addr, logic [3:0] ridx,
                             logic [31:0] data);
        sti_result_t r;
        int          pc;
        int          walk;
        int          where;
        logic [7:0]  src;
        logic [7:0]  type_byte;
        logic [31:0] sum;
        logic [31:0] value;
        bit          ok1;
        bit          ok2;
        r = '0;
        case (act)
            siu_pkg::ACT_WRITE_BYTE: begin
                arena[wrap(addr)] = data[7:0];
            end
            siu_pkg::ACT_WRITE_REG: begin
                if (ridx < REG_COUNT) regs[ridx] = data;
            end
            siu_pkg::ACT_READ_BYTE: begin
                r.read_byte = arena[wrap(addr)];
            end
            default: begin
                pc = wrap(addr);
                src = byte_at(pc + 2);
                walk = 0;
                if (reg_ok(src)) begin
                    value = regs[src - 1];
                    type_byte = byte_at(pc + 1);
                    sum = 32'h0;
                    walk = 3;
                    ok1 = add_term(pc, type_byte[5:4], walk, sum);
                    ok2 = add_term(pc, type_byte[3:2], walk, sum);
                    if (ok1 && ok2) begin
                        where = $signed(sum) % REACH;
                        for (int k = 0; k < 4; k++)
                            arena[wrap(pc + where + k)] = value[8 * (3 - k) +: 8];
                        r.stored = 1'b1;
                        r.store_address = 12'(wrap(pc + where));
                        r.stored_value = value;
                    end
                end
                r.advance = 3'(walk);
                r.next_pc = 12'(wrap(pc + walk));
            end
        endcase
        expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_result(logic [71:0] tdata);
        sti_result_t want;
        sti_result_t got;
        if (expected_q.size() == 0) begin
            $display("%0t: result with no expectation, expected none, actual %h", $time, tdata);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        got = tdata[67:0];
        compare_field("read_byte", want.read_byte, got.read_byte);
        compare_field("stored", want.stored, got.stored);
        compare_field("store_address", want.store_address, got.store_address);
        compare_field("stored_value", want.stored_value, got.stored_value);
        compare_field("advance", want.advance, got.advance);
        compare_field("next_pc", want.next_pc, got.next_pc);
        compare_field("pad", 32'h0, tdata[71:68]);
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module tb_store_indirect_instruction_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import siu_pkg::*;

    localparam int RANDOM_ITEMS = 1500;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    // input channel, every input known from time zero
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // [1:0] action
    logic [ACT_W-1:0]     s_tuser = ACT_READ_BYTE;
    // [11:0] address, [15:12] register_index, [47:16] data_word
    logic [S_TDATA_W-1:0] s_tdata = '0;

    // result channel
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [7:0] read_byte, [8] stored, [20:9] store_address, [52:21] stored_value,
    // [55:53] advance, [67:56] next_pc, [71:68] zero
    logic [M_TDATA_W-1:0] m_tdata;

    sti_scoreboard sb = new();

    // shared stimulus controls
    bit          quiet = 1'b0;        // no idling on either side while set
    bit          hold_request = 1'b0; // asks the result side for a long hold-off
    int          items_sent = 0;
    logic [11:0] region_base = 12'h0;

    store_indirect_instruction_unit #(
        .ARENA_BYTES   (ARENA_SIZE),
        .REACH_MODULUS (REACH),
        .REGISTER_COUNT(REG_COUNT)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tuser (s_tuser),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #1 aclk = ~aclk;

    // hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("** store_indirect_instruction_unit: FAILED **");
        $finish;
    end

    // offer one item and hold it until the transfer happens
    task automatic send_item(input action_t act, input logic [11:0] addr,
                             input logic [3:0] ridx, input logic [31:0] data);
        // random gap of varying length so idles land on every phase
        if (!quiet && $urandom_range(99) < 17) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {data, ridx, addr};
        do @(posedge aclk); while (!s_tready);
        // transfer taken at this edge
        sb.note_input(act, addr, ridx, data);
        items_sent++;
    endtask

    // arena byte write with random don't-care bits around the byte
    task automatic put_byte(input logic [11:0] addr, input logic [7:0] b);
        send_item(ACT_WRITE_BYTE, addr, 4'($urandom), {24'($urandom), b});
    endtask

    // stop offering until every expected result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    function automatic logic [7:0] pick_reg_byte();
        // mostly a valid register number, sometimes anything
        if ($urandom_range(99) < 88) return 8'($urandom_range(1, REG_COUNT));
        return 8'($urandom);
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return 32'h8000_0000;
            3: return 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [11:0] pick_pc();
        int sel;
        sel = $urandom_range(99);
        if (sel < 6) return 12'(ARENA_SIZE - 1 - $urandom_range(7));  // wrap at the top
        if (sel < 16) return 12'($urandom);
        return 12'(region_base + $urandom_range(1023));
    endfunction

    // lay down a store instruction with random content, then execute it
    task automatic run_instruction(input logic [11:0] pc);
        logic [7:0]  type_byte;
        logic [1:0]  code;
        logic [15:0] operand;
        int          walk;
        bit          broken;
        type_byte = 8'($urandom);
        broken = ($urandom_range(99) < 10);  // leave some bytes as they are
        put_byte(12'(pc + 1), type_byte);
        if (!broken) put_byte(12'(pc + 2), pick_reg_byte());
        walk = 3;
        for (int t = 0; t < 2; t++) begin
            code = (t == 0) ? type_byte[5:4] : type_byte[3:2];
            if (code == TERM_REG) begin
                if (!broken) put_byte(12'(pc + walk), pick_reg_byte());
                walk += 1;
            end else begin
                // indirect offsets: a quarter land near the pc, a quarter at the modulus edges, half random
                case ($urandom_range(3))
                    0: operand = 16'($urandom_range(0, 64)) - 16'd32;
                    1: operand = ($urandom_range(1)) ? 16'h01ff : 16'hfe01;
                    default: operand = 16'($urandom);
                endcase
                if (!broken) begin
                    put_byte(12'(pc + walk), operand[15:8]);
                    put_byte(12'(pc + walk + 1), operand[7:0]);
                end
                walk += 2;
            end
        end
        send_item(ACT_EXECUTE, pc, 4'($urandom), $urandom);
        // read back around the pc now and then
        if ($urandom_range(99) < 30)
            repeat ($urandom_range(1, 4))
                send_item(ACT_READ_BYTE, 12'(pc + $urandom_range(0, 1023) - 512),
                          4'($urandom), $urandom);
    endtask

    // result side: check each transfer, pick the next ready level
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
            if (hold_request) begin
                hold_left = 400;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= quiet || ($urandom_range(99) >= 17);
            end
        end
    end

    initial begin : stimulus
        int  target;
        int  pick;
        bit  held;
        bit  paused;
        held = 1'b0;
        paused = 1'b0;

        // reset once, then the block sweeps its arena with s_tready low
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // register extremes
        send_item(ACT_WRITE_REG, 12'h000, 4'd0, 32'hffff_ffff);
        send_item(ACT_WRITE_REG, 12'hfff, 4'd1, 32'h0000_0005);
        send_item(ACT_WRITE_REG, 12'h000, 4'd15, 32'h8000_0000);
        // arena address extremes
        send_item(ACT_WRITE_BYTE, 12'hfff, 4'hf, 32'hffff_ffff);
        send_item(ACT_READ_BYTE, 12'hfff, 4'h0, 32'h0);
        send_item(ACT_READ_BYTE, 12'h000, 4'hf, 32'hffff_ffff);

        // two register terms, instruction wraps past the top, negative sum
        put_byte(12'hfff, 8'h54);
        put_byte(12'h000, 8'd1);
        put_byte(12'h001, 8'd16);
        put_byte(12'h002, 8'd2);
        send_item(ACT_EXECUTE, 12'hffe, 4'h0, 32'h0);

        // two direct terms at the signed extremes, sum of minus one
        put_byte(12'd101, 8'h28);
        put_byte(12'd102, 8'd16);
        put_byte(12'd103, 8'h80);
        put_byte(12'd104, 8'h00);
        put_byte(12'd105, 8'h7f);
        put_byte(12'd106, 8'hff);
        send_item(ACT_EXECUTE, 12'd100, 4'h0, 32'h0);

        // two indirect terms, offsets at minus and plus the reach edge
        put_byte(12'd201, 8'hfc);
        put_byte(12'd202, 8'd2);
        put_byte(12'd203, 8'hfe);
        put_byte(12'd204, 8'h00);
        put_byte(12'd205, 8'h01);
        put_byte(12'd206, 8'hff);
        send_item(ACT_EXECUTE, 12'd200, 4'h0, 32'h0);

        // source register byte out of range: zero and one past the last
        put_byte(12'd302, 8'd0);
        send_item(ACT_EXECUTE, 12'd300, 4'h0, 32'h0);
        put_byte(12'd302, 8'd17);
        send_item(ACT_EXECUTE, 12'd300, 4'h0, 32'h0);

        // invalid register in a term: no store, full walk still counted
        put_byte(12'd301, 8'h10);
        put_byte(12'd302, 8'd1);
        put_byte(12'd303, 8'd0);
        send_item(ACT_EXECUTE, 12'd300, 4'h0, 32'h0);

        // random part
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            // long stretch with no idling on either side
            quiet = (items_sent >= target - 1100) && (items_sent < target - 800);
            // result side holds off while items keep coming
            if (!held && items_sent >= target - 700) begin
                held = 1'b1;
                hold_request = 1'b1;
            end
            // sender waits for the block to empty
            if (!paused && items_sent >= target - 400) begin
                paused = 1'b1;
                drain();
            end
            if ($urandom_range(99) < 5) region_base = 12'($urandom);

            pick = $urandom_range(99);
            if (pick < 55) begin
                run_instruction(pick_pc());
            end else if (pick < 70) begin
                send_item(ACT_WRITE_REG, 12'($urandom), 4'($urandom), pick_word());
            end else if (pick < 80) begin
                send_item(ACT_READ_BYTE, 12'(region_base + $urandom_range(1023)),
                          4'($urandom), $urandom);
            end else begin
                // noise: any action, any fields
                send_item(action_t'(2'($urandom)), 12'($urandom), 4'($urandom), $urandom);
            end
        end
        quiet = 1'b0;

        // let the last results come back, then allow for the longest execute
        drain();
        repeat (100) @(posedge aclk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("** store_indirect_instruction_unit: PASSED **");
        end else begin
            $display("** store_indirect_instruction_unit: FAILED **");
        end
        $finish;
    end

endmodule

@@ store_indirect_instruction_unit.f @@
hdl/siu_pkg.sv
hdl/siu_rem.sv
hdl/siu_arena.sv
hdl/siu_regfile.sv
hdl/store_indirect_instruction_unit.sv
test/tb_store_indirect_instruction_unit.sv
